// ===== src/btlv_pkg.sv =====
// ----------------------------------------------------------------------------
// btlv_pkg
// Types and constants shared by the BER TLV header encoder.
// ----------------------------------------------------------------------------
package btlv_pkg;

  localparam int MaxBytes = 11;

  localparam logic ACT_HEADER  = 1'b0;
  localparam logic ACT_INTEGER = 1'b1;

  localparam logic [30:0] ShortTagLimit = 31'd31;
  localparam logic [31:0] ShortLenLimit = 32'd128;
  localparam logic [7:0]  TagEscape     = 8'h1f;
  localparam logic [7:0]  ConsBit       = 8'h20;
  localparam logic [7:0]  LongLenFlag   = 8'h80;

  typedef logic [3:0] cnt_t;
  typedef logic [MaxBytes-1:0][7:0] frame_t;

  typedef struct packed {
    logic               action;
    logic [1:0]         id_class;
    logic               constructed;
    logic [30:0]        tag_number;
    logic [31:0]        content_length;
    logic signed [31:0] int_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    frame_t bytes;
    cnt_t   count;
  } frame_info_t;

endpackage

// ===== src/btlv_frame_build.sv =====
// ----------------------------------------------------------------------------
// btlv_frame_build
// Builds the whole byte run of one item: identifier, length and, for the
// integer action, the minimal two's complement value.
// ----------------------------------------------------------------------------
module btlv_frame_build (
  input  btlv_pkg::in_item_t    item,
  output btlv_pkg::frame_info_t frame
);

  logic        short_tag;
  logic [2:0]  ng;
  logic [5:0]  tag_shamt;
  logic [34:0] tag_al;
  logic [7:0]  id_first;
  logic [39:0] id_tail;
  logic [3:0]  ic;

  logic [2:0]  vn;
  logic [2:0]  vpad;
  logic [31:0] val_al;
  logic [3:0]  vc;

  logic [31:0] len_src;
  logic        short_len;
  logic [2:0]  nb;
  logic [2:0]  lpad;
  logic [31:0] len_sh;
  logic [39:0] len_vec;
  logic [3:0]  lc;
  logic [3:0]  il;

  logic [87:0] frame_vec;

  // identifier
  always_comb begin
    short_tag = (item.tag_number < btlv_pkg::ShortTagLimit);
    if (|item.tag_number[30:28]) begin
      ng = 3'd5;
    end else if (|item.tag_number[27:21]) begin
      ng = 3'd4;
    end else if (|item.tag_number[20:14]) begin
      ng = 3'd3;
    end else if (|item.tag_number[13:7]) begin
      ng = 3'd2;
    end else begin
      ng = 3'd1;
    end
    case (ng)
      3'd5:    tag_shamt = 6'd0;
      3'd4:    tag_shamt = 6'd7;
      3'd3:    tag_shamt = 6'd14;
      3'd2:    tag_shamt = 6'd21;
      default: tag_shamt = 6'd28;
    endcase
    tag_al = {4'b0, item.tag_number} << tag_shamt;

    id_first = {item.id_class, 6'b0};
    if (item.action == btlv_pkg::ACT_HEADER && item.constructed) begin
      id_first = id_first | btlv_pkg::ConsBit;
    end

    id_tail = '0;
    if (short_tag) begin
      id_first = id_first | {3'b0, item.tag_number[4:0]};
      ic = 4'd1;
    end else begin
      id_first = id_first | btlv_pkg::TagEscape;
      ic = 4'(ng) + 4'd1;
      for (int k = 0; k < 5; k++) begin
        if (3'(k) < ng) begin
          id_tail[39-8*k -: 8] = {(3'(k + 1) < ng), tag_al[34-7*k -: 7]};
        end
      end
    end
  end

  // integer value, minimal two's complement
  always_comb begin
    if (item.int_value[31:23] != 9'h000 && item.int_value[31:23] != 9'h1ff) begin
      vn = 3'd4;
    end else if (item.int_value[23:15] != 9'h000 && item.int_value[23:15] != 9'h1ff) begin
      vn = 3'd3;
    end else if (item.int_value[15:7] != 9'h000 && item.int_value[15:7] != 9'h1ff) begin
      vn = 3'd2;
    end else begin
      vn = 3'd1;
    end
    vpad = 3'd4 - vn;
    if (item.action == btlv_pkg::ACT_INTEGER) begin
      val_al = 32'(item.int_value) << {vpad, 3'b0};
      vc     = 4'(vn);
    end else begin
      val_al = '0;
      vc     = 4'd0;
    end
  end

  // length
  always_comb begin
    len_src = (item.action == btlv_pkg::ACT_INTEGER) ? {29'b0, vn} : item.content_length;
    short_len = (len_src < btlv_pkg::ShortLenLimit);
    if (|len_src[31:24]) begin
      nb = 3'd4;
    end else if (|len_src[23:16]) begin
      nb = 3'd3;
    end else if (|len_src[15:8]) begin
      nb = 3'd2;
    end else begin
      nb = 3'd1;
    end
    lpad   = 3'd4 - nb;
    len_sh = len_src << {lpad, 3'b0};
    if (short_len) begin
      len_vec = {len_src[7:0], 32'b0};
      lc      = 4'd1;
    end else begin
      len_vec = {btlv_pkg::LongLenFlag | {5'b0, nb}, len_sh};
      lc      = 4'(nb) + 4'd1;
    end
  end

  // assembly
  always_comb begin
    il = ic + lc;
    frame_vec = {id_first, id_tail, 40'b0}
              | ({len_vec, 48'b0} >> {ic, 3'b0})
              | ({val_al, 56'b0} >> {il, 3'b0});
    for (int i = 0; i < btlv_pkg::MaxBytes; i++) begin
      frame.bytes[i] = frame_vec[87-8*i -: 8];
    end
    if (item.action == btlv_pkg::ACT_HEADER && item.content_length == 32'd0) begin
      frame.count = 4'd0;
    end else begin
      frame.count = il + vc;
    end
  end

endmodule

// ===== src/ber_tlv_header_encoder_core.sv =====
// ----------------------------------------------------------------------------
// ber_tlv_header_encoder_core
// BER identifier/length header and primitive INTEGER TLV encoder, one byte
// per strobe with the final byte of each run marked.
// ----------------------------------------------------------------------------
// The item is held in the a stage, its frame in the byte emitter, and each
// byte is registered onto result. An item of n bytes (2 to 11) goes out as a
// run of n strobes; a zero-length header gives no transfer.
// busy is high only while an item waits behind a running one; it drops in the
// cycle the emitter reaches the running item's final byte, before it is on result.
// Synchronous reset clears all valid and control state.
module ber_tlv_header_encoder_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  btlv_pkg::in_item_t   item,
  output logic                 strobe,
  output btlv_pkg::out_item_t  result
);

  logic                  a_valid;
  btlv_pkg::in_item_t    a_item;
  btlv_pkg::frame_info_t a_frame;

  logic                  b_valid;
  btlv_pkg::frame_t      b_bytes;
  btlv_pkg::cnt_t        b_count;
  btlv_pkg::cnt_t        b_idx;

  logic                  accept;
  logic                  a_move;
  logic                  b_done;
  logic                  b_load;

  btlv_frame_build u_build (
    .item  (a_item),
    .frame (a_frame)
  );

  assign b_done = b_valid && (b_idx == b_count - 4'd1);
  assign a_move = a_valid && (!b_valid || b_done || a_frame.count == 4'd0);
  assign b_load = a_move && (a_frame.count != 4'd0);
  assign busy   = a_valid && !a_move;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_idx   <= '0;
    end else if (b_load) begin
      b_valid <= 1'b1;
      b_idx   <= '0;
    end else if (b_done) begin
      b_valid <= 1'b0;
    end else if (b_valid) begin
      b_idx <= b_idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_bytes <= a_frame.bytes;
      b_count <= a_frame.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    result.out_byte <= b_bytes[b_idx];
    result.last     <= b_done;
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (b_idx < b_count))
    else $error("emitter index beyond frame length");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last) |=> strobe)
    else $error("byte run broken before last");

  a_idx_steps: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !b_done && !b_load) |=> (b_valid && b_idx == $past(b_idx) + 4'd1))
    else $error("emitter index did not advance");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    b_load |-> (!b_valid || b_done))
    else $error("frame loaded over a running frame");

  a_busy_held: assert property (@(posedge clk) disable iff (rst)
    busy |=> a_valid)
    else $error("pending item lost while busy");

endmodule
